FILE: hw/rtl/pixel_sample_average_buffer_macros.svh
// Assertion macros for the pixel sample average buffer.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef PIXEL_SAMPLE_AVERAGE_BUFFER_MACROS_SVH
`define PIXEL_SAMPLE_AVERAGE_BUFFER_MACROS_SVH

// same-cycle implication
`define PSAB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSAB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/psab_pkg.sv
// Shared types and constants for the pixel sample average buffer.
// No dependencies.
package psab_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_SUM_BITS   = 32;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CFG_W      = 9;
  localparam int COORD_W    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int AVG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int LANES      = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic REG_ACTIVE_HEIGHT = 1'b1;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [SAMPLE_W-1:0] sample_red;
    logic [SAMPLE_W-1:0] sample_green;
    logic [SAMPLE_W-1:0] sample_blue;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [AVG_W-1:0]    average_red;
    logic [AVG_W-1:0]    average_green;
    logic [AVG_W-1:0]    average_blue;
    logic [AVG_W-1:0]    samples_taken;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/psab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/psab_div.sv
// Three-lane radix-2 restoring divider, one quotient bit per lane per cycle.
// Quotient saturates at the 16-bit maximum; a zero divisor gives zero.
// Depends on psab_pkg.
module psab_div #(
  parameter int SUM_BITS   = psab_pkg::DEF_SUM_BITS,
  parameter int COUNT_BITS = psab_pkg::DEF_COUNT_BITS
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [psab_pkg::LANES-1:0][SUM_BITS-1:0]       dividend,
  input  logic [COUNT_BITS-1:0]                          divisor,
  output logic [psab_pkg::LANES-1:0][psab_pkg::AVG_W-1:0] quotient,
  output psab_pkg::div_stat_t                            stat
);
  import psab_pkg::*;

  localparam int REM_W  = COUNT_BITS + 1;
  localparam int HI_W   = SUM_BITS - AVG_W;
  localparam int CMP_W  = (HI_W > COUNT_BITS) ? HI_W : COUNT_BITS;
  localparam int STEP_W = $clog2(AVG_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(AVG_W - 1);

  logic                               busy;
  logic                               done;
  logic [STEP_W-1:0]                  step;
  logic [COUNT_BITS-1:0]              dvsr;
  logic                               dvsr_zero;
  logic [LANES-1:0]                   sat;
  logic [LANES-1:0][REM_W-1:0]        rem;
  logic [LANES-1:0][AVG_W-1:0]        lo;
  logic [LANES-1:0][REM_W-1:0]        rem_sh;
  logic [LANES-1:0][REM_W-1:0]        rem_next;
  logic [LANES-1:0][AVG_W-1:0]        lo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder starts as the upper dividend bits; only valid when not saturated
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr      <= divisor;
      dvsr_zero <= (divisor == '0);
      for (int l = 0; l < LANES; l++) begin
        sat[l] <= (CMP_W'(dividend[l] >> AVG_W) >= CMP_W'(divisor));
        rem[l] <= REM_W'(dividend[l] >> AVG_W);
        lo[l]  <= dividend[l][AVG_W-1:0];
      end
    end else if (busy) begin
      rem <= rem_next;
      lo  <= lo_next;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l] = {rem[l][COUNT_BITS-1:0], lo[l][AVG_W-1]};
      if (rem_sh[l] >= {1'b0, dvsr}) begin
        rem_next[l] = rem_sh[l] - {1'b0, dvsr};
        lo_next[l]  = {lo[l][AVG_W-2:0], 1'b1};
      end else begin
        rem_next[l] = rem_sh[l];
        lo_next[l]  = {lo[l][AVG_W-2:0], 1'b0};
      end
      if (dvsr_zero) begin
        quotient[l] = '0;
      end else if (sat[l]) begin
        quotient[l] = '1;
      end else begin
        quotient[l] = lo[l];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hw/rtl/pixel_sample_average_buffer.sv
// Pixel sample average buffer: per-pixel RGB sums and counts with running average.
// Depends on psab_pkg, psab_ram, psab_div and pixel_sample_average_buffer_macros.svh.
//
// Usage:
//   item channel (item_valid/item_ready, item): an add word names a pixel and an
//   RGB sample; a clear word zeroes every pixel inside active_width x active_height.
//   result channel (result_valid/result_ready, result): one word per add, none per
//   clear. Status flags out-of-range coordinates and full pixels.
//   APB port: active_width at 0x0, active_height at 0x4, pready tied high.
// Sequence:
//   An add word goes from acceptance through address multiply, RAM read, update
//   and write-back, then the shared three-lane divider, to its result. An
//   out-of-range add skips the RAM read and the divider. A clear holds
//   item_ready low while it zeroes width*height entries.
//   One word is in flight at a time.
// Reset:
//   After rst the whole pixel RAM (MAX_WIDTH*MAX_HEIGHT entries) is zeroed, one
//   entry per cycle; item_ready stays low during that pass. Register writes are
//   taken at any time.
// Stall:
//   A result waits in the output register; the next word is accepted and worked
//   on, and only its own result waits for the register to drain.
`include "pixel_sample_average_buffer_macros.svh"

module pixel_sample_average_buffer #(
  parameter int MAX_WIDTH  = psab_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = psab_pkg::DEF_MAX_HEIGHT,
  parameter int SUM_BITS   = psab_pkg::DEF_SUM_BITS,
  parameter int COUNT_BITS = psab_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  psab_pkg::in_word_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output psab_pkg::out_word_t                 result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psab_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [psab_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [psab_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import psab_pkg::*;

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int MEM_W  = LANES * SUM_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * CFG_W;
  localparam int CW     = (COUNT_BITS > AVG_W) ? COUNT_BITS : AVG_W;
  localparam logic [CFG_W-1:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : CFG_W'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_PIXEL = ADDR_W'(PIXELS - 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_READ   = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_CLEAR  = 4'd8;

  logic [3:0]                          state;
  logic [3:0]                          state_next;
  logic [CFG_W-1:0]                    active_width;
  logic [CFG_W-1:0]                    active_height;
  logic [CFG_W-1:0]                    w_eff;
  logic [CFG_W-1:0]                    h_eff;
  in_word_t                            cur;
  logic [PROD_W-1:0]                   prod;
  logic [PROD_W-1:0]                   prod_next;
  logic [CFG_W-1:0]                    mul_b;
  logic                                oor;
  logic [ADDR_W-1:0]                   clr_addr;
  logic [ADDR_W-1:0]                   clr_last;
  logic [ADDR_W-1:0]                   idx;
  logic [LANES-1:0][SUM_BITS-1:0]      opnd_sum;
  logic [COUNT_BITS-1:0]               opnd_cnt;
  logic [STATUS_W-1:0]                 st;
  logic [LANES-1:0][SAMPLE_W-1:0]      samp;
  logic [LANES-1:0][SUM_BITS-1:0]      rd_sum;
  logic [COUNT_BITS-1:0]               rd_cnt;
  logic [LANES-1:0][SUM_BITS:0]        sum_ext;
  logic [LANES-1:0][SUM_BITS-1:0]      new_sum;
  logic [LANES-1:0]                    carry;
  logic                                full;
  logic                                ram_we;
  logic                                ram_re;
  logic [ADDR_W-1:0]                   ram_waddr;
  logic [MEM_W-1:0]                    ram_wdata;
  logic [MEM_W-1:0]                    ram_rdata;
  logic                                div_start;
  logic [LANES-1:0][AVG_W-1:0]         quot;
  div_stat_t                           div_stat;
  logic [CW-1:0]                       cnt_wide;
  logic [AVG_W-1:0]                    taken;
  logic                                clearing;
  logic                                cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= CFG_RESET;
      active_height <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE_WIDTH:  active_width  <= pwdata[CFG_W-1:0];
        REG_ACTIVE_HEIGHT: active_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_WIDTH:  prdata = APB_DATA_W'(active_width);
      REG_ACTIVE_HEIGHT: prdata = APB_DATA_W'(active_height);
      default:           prdata = '0;
    endcase
  end

  assign w_eff = (active_width > W_CAP) ? W_CAP : active_width;
  assign h_eff = (active_height > H_CAP) ? H_CAP : active_height;

  // ---------------- sequencer ----------------
  assign item_ready = (state == S_IDLE);
  assign clearing   = (state inside {S_INIT, S_CLEAR});

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   if (clr_addr == clr_last) state_next = S_IDLE;
      S_IDLE:   if (item_valid) state_next = S_ADDR;
      S_ADDR:   state_next = S_READ;
      S_READ: begin
        if (cur.kind == KIND_CLEAR) begin
          state_next = (prod == '0) ? S_IDLE : S_CLEAR;
        end else if (oor) begin
          state_next = S_OUT;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_stat.done) state_next = S_OUT;
      S_OUT:    if (!result_valid || result_ready) state_next = S_IDLE;
      S_CLEAR:  if (clr_addr == clr_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      clr_last <= LAST_PIXEL;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_READ && cur.kind == KIND_CLEAR) begin
        clr_addr <= '0;
        clr_last <= ADDR_W'(prod - PROD_W'(1));
      end
    end
  end

  // ---------------- address and range ----------------
  // one multiplier: y*w+x for an add, w*h for a clear
  assign mul_b     = (cur.kind == KIND_CLEAR) ? h_eff : CFG_W'(cur.pixel_y);
  assign prod_next = PROD_W'(w_eff * mul_b)
                   + ((cur.kind == KIND_CLEAR) ? '0 : PROD_W'(cur.pixel_x));

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cur <= item;
    end
    if (state == S_ADDR) begin
      prod <= prod_next;
      oor  <= (CFG_W'(cur.pixel_x) >= w_eff) || (CFG_W'(cur.pixel_y) >= h_eff);
    end
  end

  assign idx = ADDR_W'(prod);

  // ---------------- update ----------------
  assign samp[0] = cur.sample_red;
  assign samp[1] = cur.sample_green;
  assign samp[2] = cur.sample_blue;
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rd_sum[l]  = ram_rdata[COUNT_BITS + l * SUM_BITS +: SUM_BITS];
      sum_ext[l] = {1'b0, rd_sum[l]} + (SUM_BITS + 1)'(samp[l]);
      carry[l]   = sum_ext[l][SUM_BITS];
      new_sum[l] = sum_ext[l][SUM_BITS-1:0];
    end
  end

  // drop the sample when the count is saturated or any channel would wrap
  assign full = (rd_cnt == '1) || (carry != '0);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      st <= oor ? ST_RANGE : ST_OK;
    end
    if (state == S_CHECK) begin
      if (full) begin
        opnd_sum <= rd_sum;
        opnd_cnt <= rd_cnt;
        st       <= ST_FULL;
      end else begin
        opnd_sum <= new_sum;
        opnd_cnt <= rd_cnt + 1'b1;
        st       <= ST_OK;
      end
    end
  end

  assign ram_re    = (state == S_READ) && (cur.kind == KIND_ADD) && !oor;
  assign ram_we    = clearing || ((state == S_CHECK) && !full);
  assign ram_waddr = clearing ? clr_addr : idx;
  assign ram_wdata = clearing ? '0 : {new_sum, rd_cnt + 1'b1};

  psab_ram #(
    .WIDTH (MEM_W),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // ---------------- averages ----------------
  assign div_start = (state == S_DSTART);

  psab_div #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opnd_sum),
    .divisor  (opnd_cnt),
    .quotient (quot),
    .stat     (div_stat)
  );

  assign cnt_wide = CW'(opnd_cnt);
  assign taken    = (cnt_wide > CW'({AVG_W{1'b1}})) ? '1 : AVG_W'(cnt_wide);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || result_ready)) begin
      result.out_x  <= cur.pixel_x;
      result.out_y  <= cur.pixel_y;
      result.status <= st;
      if (st == ST_RANGE) begin
        result.average_red   <= '0;
        result.average_green <= '0;
        result.average_blue  <= '0;
        result.samples_taken <= '0;
      end else begin
        result.average_red   <= quot[0];
        result.average_green <= quot[1];
        result.average_blue  <= quot[2];
        result.samples_taken <= taken;
      end
    end
  end

  // ---------------- checks ----------------
  `PSAB_ASSERT_NXT(a_one_word, item_valid && item_ready, !item_ready, "second word taken while busy")
  `PSAB_ASSERT_IMP(a_div_done, div_stat.done, state == S_DIV, "divider finished outside its wait state")
  `PSAB_ASSERT_IMP(a_ok_count, result_valid && result.status == ST_OK, result.samples_taken != '0, "ok result with zero count")
  `PSAB_ASSERT_IMP(a_clr_bound, state == S_INIT || state == S_CLEAR, clr_addr <= clr_last, "clear pass ran past its end")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for pixel_sample_average_buffer: random and directed sample
// and clear words, APB register setup, per-pixel sum/count prediction, result checks.
// Depends on psab_pkg and the pixel_sample_average_buffer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psab_pkg::*;

  localparam int unsigned PIXELS     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int unsigned COUNT_FULL = (1 << DEF_COUNT_BITS) - 1;
  localparam int          CYCLE_LIMIT = 8_000_000;
  localparam int          LONG_HOLD   = 600;
  localparam int          PIXEL_RUN   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       item_valid = 1'b0;
  logic       item_ready;
  in_word_t   item_word = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_word_t  result_word;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pixel_sample_average_buffer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the pixel store and registers
  bit [31:0]       red_sum   [PIXELS];
  bit [31:0]       green_sum [PIXELS];
  bit [31:0]       blue_sum  [PIXELS];
  int unsigned     pixel_count [PIXELS];
  logic [CFG_W-1:0] cfg_width  = CFG_RESET;
  logic [CFG_W-1:0] cfg_height = CFG_RESET;

  in_word_t  words_to_send [$];
  out_word_t expected_averages [$];

  int  cycle_count = 0;
  int  clear_busy_until = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  long_hold_left = 0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  bit  no_gaps = 1'b0;
  int  mismatches = 0;
  int  words_taken = 0;
  int  clears_taken = 0;
  int  range_hits = 0;
  int  full_hits = 0;
  int  results_checked = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned eff_width();
    return (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
  endfunction

  function automatic logic [AVG_W-1:0] channel_mean(bit [31:0] sum, int unsigned cnt);
    bit [31:0] q;
    if (cnt == 0) return '0;
    q = sum / cnt;
    return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // zeroes the active area, returns the number of pixels cleared
  function automatic int unsigned clear_pixels();
    int unsigned area;
    area = eff_width() * eff_height();
    for (int unsigned i = 0; i < area; i++) begin
      red_sum[i] = '0;
      green_sum[i] = '0;
      blue_sum[i] = '0;
      pixel_count[i] = 0;
    end
    return area;
  endfunction

  function automatic out_word_t predict_average(in_word_t w);
    out_word_t   o;
    int unsigned ew, eh, idx, cnt;
    bit [32:0]   r_new, g_new, b_new;
    o = '0;
    ew = eff_width();
    eh = eff_height();
    o.out_x = w.pixel_x;
    o.out_y = w.pixel_y;
    if (w.pixel_x >= ew || w.pixel_y >= eh) begin
      o.status = ST_RANGE;
      return o;
    end
    idx = w.pixel_y * ew + w.pixel_x;
    cnt = pixel_count[idx];
    r_new = {1'b0, red_sum[idx]} + 33'(w.sample_red);
    g_new = {1'b0, green_sum[idx]} + 33'(w.sample_green);
    b_new = {1'b0, blue_sum[idx]} + 33'(w.sample_blue);
    if (cnt >= COUNT_FULL || r_new[32] || g_new[32] || b_new[32]) begin
      o.status = ST_FULL;
    end else begin
      red_sum[idx] = r_new[31:0];
      green_sum[idx] = g_new[31:0];
      blue_sum[idx] = b_new[31:0];
      cnt++;
      pixel_count[idx] = cnt;
      o.status = ST_OK;
    end
    o.average_red   = channel_mean(red_sum[idx], cnt);
    o.average_green = channel_mean(green_sum[idx], cnt);
    o.average_blue  = channel_mean(blue_sum[idx], cnt);
    o.samples_taken = (cnt > 32'hFFFF) ? 16'hFFFF : cnt[15:0];
    return o;
  endfunction

  function automatic in_word_t make_word(logic kind, logic [COORD_W-1:0] x,
                                         logic [COORD_W-1:0] y, logic [SAMPLE_W-1:0] r,
                                         logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] b);
    in_word_t w;
    w.kind = kind;
    w.pixel_x = x;
    w.pixel_y = y;
    w.sample_red = r;
    w.sample_green = g;
    w.sample_blue = b;
    return w;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender: one word at a time from the queue, random gaps between words unless no_gaps is set
  always @(posedge clk) begin
    out_word_t p;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        words_taken++;
        if (item_word.kind == KIND_CLEAR) begin
          clears_taken++;
          clear_busy_until = cycle_count + clear_pixels() + 16;
        end else begin
          p = predict_average(item_word);
          if (p.status == ST_RANGE) range_hits++;
          if (p.status == ST_FULL) full_hits++;
          expected_averages.push_back(p);
        end
      end
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          item_word <= words_to_send.pop_front();
          item_valid <= 1'b1;
          send_gap <= no_gaps ? 0 : pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls (none while no_gaps is set), plus one long hold-off so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      result_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      long_hold_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (no_gaps) begin
      result_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= pick_gap();
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_averages.size() == 0) begin
        $error("result word with nothing expected: x=%0d y=%0d",
               result_word.out_x, result_word.out_y);
        mismatches++;
      end else begin
        want = expected_averages.pop_front();
        results_checked++;
        check_field("out_x", 16'(want.out_x), 16'(result_word.out_x));
        check_field("out_y", 16'(want.out_y), 16'(result_word.out_y));
        check_field("average_red", want.average_red, result_word.average_red);
        check_field("average_green", want.average_green, result_word.average_green);
        check_field("average_blue", want.average_blue, result_word.average_blue);
        check_field("samples_taken", want.samples_taken, result_word.samples_taken);
        check_field("status", 16'(want.status), 16'(result_word.status));
      end
    end
  end

  // all words sent, all results back, and any clear sweep has had time to finish
  task automatic wait_idle();
    while (words_to_send.size() != 0 || item_valid || expected_averages.size() != 0 ||
           cycle_count < clear_busy_until)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {23'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ACTIVE_WIDTH) cfg_width = value;
    else cfg_height = value;
  endtask

  task automatic set_area(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_ACTIVE_WIDTH, w);
    write_reg(REG_ACTIVE_HEIGHT, h);
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    int unsigned ew, eh;
    int sel;
    logic [COORD_W-1:0] x, y;
    ew = eff_width();
    eh = eff_height();
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      x = COORD_W'($urandom_range(0, 255));
      y = COORD_W'($urandom_range(0, 255));
      if (sel < 5 && ew * eh <= 4096) begin
        words_to_send.push_back(make_word(KIND_CLEAR, x, y, pick_sample(),
                                          pick_sample(), pick_sample()));
        continue;
      end
      if (ew != 0 && eh != 0 && sel >= 15) begin
        if (sel < 22 && ew < 256) begin
          x = COORD_W'(ew);  // just past the right edge
          y = COORD_W'($urandom_range(0, eh - 1));
        end else if (sel < 50) begin
          // a few hot pixels keep counts climbing
          x = COORD_W'($urandom_range(0, (ew < 4 ? ew : 4) - 1));
          y = COORD_W'($urandom_range(0, (eh < 4 ? eh : 4) - 1));
        end else begin
          x = COORD_W'($urandom_range(0, ew - 1));
          y = COORD_W'($urandom_range(0, eh - 1));
        end
      end
      words_to_send.push_back(make_word(KIND_ADD, x, y, pick_sample(),
                                        pick_sample(), pick_sample()));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default 256x256 area straight out of reset
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, '0, '0, '0));
    words_to_send.push_back(make_word(KIND_ADD, 255, 255, 16'h1234, 16'h8000, 16'hFFFF));
    words_to_send.push_back(make_word(KIND_ADD, 255, 0, 16'h0001, 16'h0002, 16'h0003));
    words_to_send.push_back(make_word(KIND_ADD, 0, 255, 16'hAAAA, 16'h5555, 16'h1000));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h0001, 16'h0002, 16'h0003));
    words_to_send.push_back(make_word(KIND_CLEAR, 8'hFF, 8'hFF, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h0800, 16'h0FFF, 16'h7FFF));

    // zero width or height: nothing is in range and a clear touches nothing
    set_area(0, 0);
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_CLEAR, 0, 0, '0, '0, '0));
    set_area(5, 0);
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h0100, 16'h0200, 16'h0300));

    // oversized registers fall back to the full 256x256 area
    set_area(9'd511, 9'd511);
    words_to_send.push_back(make_word(KIND_ADD, 255, 255, 16'h4000, 16'h3000, 16'h2000));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h0001, 16'h0001, 16'h0001));

    set_area(3, 2);
    words_to_send.push_back(make_word(KIND_ADD, 3, 0, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_ADD, 0, 2, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_ADD, 2, 1, 16'hFFFF, 16'h0000, 16'h8001));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h1111, 16'h2222, 16'h3333));
    words_to_send.push_back(make_word(KIND_CLEAR, 8'hA5, 8'h5A, '1, '0, '1));
    words_to_send.push_back(make_word(KIND_ADD, 0, 0, 16'h0FFF, 16'h0FFF, 16'h0FFF));

    // single pixel hit back to back, then just past both of its edges
    set_area(1, 1);
    no_gaps = 1'b1;
    words_to_send.push_back(make_word(KIND_CLEAR, 0, 0, '0, '0, '0));
    for (int i = 0; i < PIXEL_RUN; i++)
      words_to_send.push_back(make_word(KIND_ADD, 0, 0, pick_sample(), pick_sample(),
                                        pick_sample()));
    words_to_send.push_back(make_word(KIND_ADD, 1, 0, '1, '1, '1));
    words_to_send.push_back(make_word(KIND_ADD, 0, 1, '1, '1, '1));
    wait_idle();
    no_gaps = 1'b0;

    set_area(16, 9);
    long_hold_req = 1'b1;
    queue_random(150);
    set_area(9'd511, 256);
    queue_random(150);
    set_area(1, 256);
    queue_random(150);
    set_area(256, 1);
    queue_random(150);
    set_area(40, 30);
    no_gaps = 1'b1;
    queue_random(150);
    wait_idle();
    no_gaps = 1'b0;
    set_area(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)));
    queue_random(150);
    wait_idle();

    $display("Sent %0d words (%0d clears); checked %0d results, %0d out of range, %0d full",
             words_taken, clears_taken, results_checked, range_hits, full_hits);
    $display("Areas from 0x0 through clamped 511x511, back-to-back hits on a single pixel");
    if (mismatches == 0 && expected_averages.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/psab_pkg.sv
hw/rtl/psab_ram.sv
hw/rtl/psab_div.sv
hw/rtl/pixel_sample_average_buffer.sv
verif/tb_top.sv
